// ===== rtl/tdts_pkg.sv =====
// ----------------------------------------------------------------------------
// Tick-driven task scheduler package
// Shared constants, types and the ordering function of the ready queue.
// ----------------------------------------------------------------------------
package tdts_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CountBits  = $clog2(QueueDepth + 1);
  localparam int unsigned IdxBits    = $clog2(QueueDepth);
  localparam int unsigned TimeBits   = 16;
  localparam int unsigned FifoDepth  = 2;

  typedef logic [TimeBits-1:0] time_t;

  // Scheduling modes.
  localparam logic [1:0] ModeFcfs = 2'd0;
  localparam logic [1:0] ModeSjf  = 2'd1;
  localparam logic [1:0] ModePrio = 2'd2;
  localparam logic [1:0] ModeRr   = 2'd3;

  // Register indexes.
  localparam logic RegMode    = 1'b0;
  localparam logic RegQuantum = 1'b1;

  // Command codes.
  localparam logic CmdArrive = 1'b0;
  localparam logic CmdTick   = 1'b1;

  // Event codes.
  localparam logic [2:0] EvNone    = 3'd0;
  localparam logic [2:0] EvFinish  = 3'd1;
  localparam logic [2:0] EvPreempt = 3'd2;
  localparam logic [2:0] EvIdle    = 3'd3;
  localparam logic [2:0] EvDrop    = 3'd4;

  // One ready queue entry.
  typedef struct packed {
    logic [7:0] id;
    logic [7:0] burst;
    logic [7:0] prio;
    time_t      arr;
    logic       requeued;
  } entry_t;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic       cmd;
    logic [7:0] task_id;
    logic [7:0] burst;
    logic [7:0] prio;
    logic       more;
  } req_t;

  // True if a must stand strictly before b.
  function automatic logic goes_before(input logic [1:0] mode, input entry_t a,
                                       input entry_t b);
    logic r;
    if (mode == ModeSjf && a.burst != b.burst) begin
      r = a.burst < b.burst;
    end else if (mode == ModePrio && a.prio != b.prio) begin
      r = a.prio < b.prio;
    end else if (a.arr != b.arr) begin
      r = a.arr < b.arr;
    end else if (a.requeued != b.requeued) begin
      r = a.requeued;
    end else begin
      r = a.id < b.id;
    end
    return r;
  endfunction

endpackage

// ===== rtl/tdts_front.sv =====
// ----------------------------------------------------------------------------
// Scheduler front end
// Accepts requests and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module tdts_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  tdts_pkg::req_t  req_i,
  output logic            req_valid_o,
  input  logic            req_take_i,
  output tdts_pkg::req_t  req_o
);
  import tdts_pkg::*;

  localparam int unsigned PtrBits = $clog2(FifoDepth);

  req_t                 mem_q [FifoDepth];
  logic [PtrBits-1:0]   wr_q, rd_q;
  logic [PtrBits:0]     cnt_q;
  logic                 do_push, do_pop;

  assign full        = cnt_q == (PtrBits+1)'(FifoDepth);
  assign req_valid_o = cnt_q != '0;
  assign req_o       = mem_q[rd_q];
  assign do_push     = push && !full;
  assign do_pop      = req_take_i && req_valid_o;

  // Storage of waiting requests.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= req_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrBits+1)'(do_push) - (PtrBits+1)'(do_pop);
    end
  end

endmodule

// ===== rtl/tdts_back.sv =====
// ----------------------------------------------------------------------------
// Scheduler back end
// Carries out arrivals and ticks on the sorted ready queue and keeps time.
// ----------------------------------------------------------------------------
module tdts_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [7:0]      cfg_data_i,
  input  logic            req_valid_i,
  output logic            req_take_o,
  input  tdts_pkg::req_t  req_i,
  output logic            empty,
  input  logic            pop,
  output logic [2:0]      event_kind_o,
  output logic [7:0]      event_task_o,
  output logic [15:0]     span_start_o,
  output logic [15:0]     span_end_o,
  output logic [31:0]     waiting_total_o,
  output logic            busy_res_o,
  output logic [4:0]      queued_o
);
  import tdts_pkg::*;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StSlice  = 4'b0010,
    StInsert = 4'b0100,
    StDisp   = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  entry_t               q_q [QueueDepth];
  logic [CountBits-1:0] cnt_q;
  entry_t               cur_q;
  time_t                now_q, disp_q, idle_beg_q;
  logic                 run_q, idlef_q;
  logic [31:0]          wacc_q;
  logic [1:0]           mode_q;
  logic [7:0]           quant_q;
  req_t                 req_q;
  entry_t               ins_q;
  logic [2:0]           kind_q;
  logic [7:0]           task_q;
  time_t                s0_q, s1_q;
  logic                 ovalid_q;

  time_t                el;
  logic [7:0]           qeff;
  logic [QueueDepth-1:0] ahead;
  logic [IdxBits-1:0]   pos;
  logic                 ready_full;

  assign ready_full = cnt_q == CountBits'(QueueDepth);
  assign el         = now_q - disp_q;
  assign qeff       = (quant_q == 8'd0) ? 8'd1 : quant_q;

  // Parallel compare of the new entry against every stored one.
  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      ahead[i] = (CountBits'(i) < cnt_q) &&
                 ((mode_q == ModeFcfs) ? 1'b0 : goes_before(mode_q, ins_q, q_q[i]));
    end
    pos = cnt_q[IdxBits-1:0];
    for (int i = QueueDepth - 1; i >= 0; i--) begin
      if (ahead[i]) begin
        pos = IdxBits'(i);
      end
    end
  end

  assign req_take_o = state_q == StIdle && !ovalid_q && req_valid_i;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (req_take_o) begin
                  state_d = (req_i.cmd == CmdTick) ? StSlice : StInsert;
                end
      StSlice:  state_d = StInsert;
      StInsert: state_d = (req_q.cmd == CmdTick) ? StDisp : StIdle;
      StDisp:   state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Queue payload: insert and shift.
  always_ff @(posedge clk_i) begin
    if (state_q == StInsert && !(req_q.cmd == CmdArrive && ready_full) &&
        !(req_q.cmd == CmdTick && kind_q != EvPreempt)) begin
      for (int i = 0; i < QueueDepth; i++) begin
        if (IdxBits'(i) == pos) begin
          q_q[i] <= ins_q;
        end else if (IdxBits'(i) > pos && i > 0) begin
          q_q[i] <= q_q[(i > 0) ? i - 1 : 0];
        end
      end
    end else if (state_q == StDisp && !run_q && cnt_q != '0) begin
      for (int i = 0; i < QueueDepth - 1; i++) begin
        q_q[i] <= q_q[i+1];
      end
    end
  end

  // Control state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cnt_q      <= '0;
      now_q      <= '0;
      disp_q     <= '0;
      idle_beg_q <= '0;
      run_q      <= 1'b0;
      idlef_q    <= 1'b0;
      wacc_q     <= '0;
      mode_q     <= ModeFcfs;
      quant_q    <= 8'd2;
      ovalid_q   <= 1'b0;
      kind_q     <= EvNone;
      task_q     <= '0;
      s0_q       <= '0;
      s1_q       <= '0;
      req_q      <= '0;
      ins_q      <= '0;
      cur_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegMode) begin
          mode_q <= cfg_data_i[1:0];
        end else begin
          quant_q <= cfg_data_i;
        end
      end
      if (pop && ovalid_q) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (req_take_o) begin
            req_q  <= req_i;
            kind_q <= EvNone;
            task_q <= '0;
            s0_q   <= '0;
            s1_q   <= '0;
            ins_q  <= '{id: req_i.task_id, burst: req_i.burst, prio: req_i.prio,
                        arr: now_q, requeued: 1'b0};
          end
        end
        StSlice: begin
          // Finish or preempt the running task.
          if (run_q) begin
            if (TimeBits'(cur_q.burst) <= el) begin
              kind_q <= EvFinish;
              task_q <= cur_q.id;
              s0_q   <= now_q - TimeBits'(cur_q.burst);
              s1_q   <= now_q;
              wacc_q <= wacc_q + 32'(time_t'(now_q - TimeBits'(cur_q.burst) - cur_q.arr));
              run_q  <= 1'b0;
            end else if (mode_q == ModeRr && !ready_full && TimeBits'(qeff) <= el) begin
              kind_q <= EvPreempt;
              task_q <= cur_q.id;
              s0_q   <= now_q - TimeBits'(qeff);
              s1_q   <= now_q;
              wacc_q <= wacc_q + 32'(time_t'(now_q - TimeBits'(qeff) - cur_q.arr));
              run_q  <= 1'b0;
              ins_q  <= '{id: cur_q.id, burst: cur_q.burst - qeff, prio: cur_q.prio,
                          arr: now_q, requeued: 1'b1};
            end
          end
        end
        StInsert: begin
          if (req_q.cmd == CmdArrive) begin
            if (ready_full) begin
              kind_q <= EvDrop;
              task_q <= req_q.task_id;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
            ovalid_q <= 1'b1;
          end else if (kind_q == EvPreempt) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StDisp: begin
          // Dispatch the head, then track idle spans and advance time.
          if (!run_q && cnt_q != '0) begin
            if (idlef_q) begin
              kind_q  <= EvIdle;
              task_q  <= '0;
              s0_q    <= idle_beg_q;
              s1_q    <= now_q;
              idlef_q <= 1'b0;
            end
            cur_q  <= q_q[0];
            cnt_q  <= cnt_q - 1'b1;
            run_q  <= 1'b1;
            disp_q <= now_q;
          end else if (!run_q && req_q.more && !idlef_q) begin
            idlef_q    <= 1'b1;
            idle_beg_q <= now_q;
          end
          now_q    <= now_q + 1'b1;
          ovalid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // The slice state always passes through the insert state for requeue.
  assign empty           = !ovalid_q;
  assign event_kind_o    = kind_q;
  assign event_task_o    = task_q;
  assign span_start_o    = 16'(s0_q);
  assign span_end_o      = 16'(s1_q);
  assign waiting_total_o = wacc_q;
  assign busy_res_o      = run_q;
  assign queued_o        = 5'(cnt_q);

endmodule

// ===== rtl/tick_driven_task_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// Tick-driven task scheduler core
// Single-processor scheduler with a sorted ready queue and tick events.
// ----------------------------------------------------------------------------
// Requests enter through push/full as a queue; each gives one result,
// read through empty/pop. A request with cmd low inserts a task at the
// current time; with cmd high it runs one scheduling tick.
// The back end handles an arrival as take then insertion, and a tick as
// take, slice end, requeue insertion and dispatch, all set by
// the single sequencer over the ready queue; the result shows on the cycle
// after the last of these. A new request is taken only once the previous
// result has been popped. A two-entry request queue lets the sender run
// ahead. The result register holds until popped; while it is full the back
// end takes no new request, and the request queue fills. Reset empties
// both queues, clears time and statistics, sets first come first served
// mode and a quantum of two. Configuration is written at cfg_we_i with
// index cfg_idx_i; the user must write it only while the block is idle,
// which the block itself does not enforce.
// ----------------------------------------------------------------------------
module tick_driven_task_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic        cmd_i,
  input  logic [7:0]  task_id_i,
  input  logic [7:0]  burst_ticks_i,
  input  logic [7:0]  prio_level_i,
  input  logic        more_pending_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  event_kind_o,
  output logic [7:0]  event_task_o,
  output logic [15:0] span_start_o,
  output logic [15:0] span_end_o,
  output logic [31:0] waiting_total_o,
  output logic        busy_res_o,
  output logic [4:0]  queued_o
);
  import tdts_pkg::*;

  req_t in_req, fifo_req;
  logic req_valid, req_take;

  assign in_req = '{cmd: cmd_i, task_id: task_id_i, burst: burst_ticks_i,
                    prio: prio_level_i, more: more_pending_i};

  // Request queue.
  tdts_front u_front (
    .clk_i, .rst_ni, .push, .full, .req_i(in_req),
    .req_valid_o(req_valid), .req_take_i(req_take), .req_o(fifo_req)
  );

  // Scheduling engine.
  tdts_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_valid_i(req_valid), .req_take_o(req_take), .req_i(fifo_req),
    .empty, .pop, .event_kind_o, .event_task_o, .span_start_o, .span_end_o,
    .waiting_total_o, .busy_res_o, .queued_o
  );

endmodule

// ===== rtl/tdts_checker.sv =====
// ----------------------------------------------------------------------------
// Tick-driven task scheduler checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module tdts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  event_kind_o,
  input logic [4:0]  queued_o,
  input logic        busy_res_o,
  input logic [31:0] waiting_total_o
);
  import tdts_pkg::*;

  // A waiting result holds until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(event_kind_o) && $stable(waiting_total_o))
    else $error("result changed while stalled");

  // While a result waits, the ready count does not exceed the depth.
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> queued_o <= 5'(QueueDepth))
    else $error("ready count beyond depth");

  // Event codes stay in range.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> event_kind_o <= EvDrop)
    else $error("bad event code");

  // A preempt or an ended idle span is always followed by a dispatch.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (event_kind_o == EvPreempt || event_kind_o == EvIdle) |-> busy_res_o)
    else $error("no task running after dispatch");

  // A dropped arrival leaves a full queue.
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && event_kind_o == EvDrop |-> queued_o == 5'(QueueDepth))
    else $error("drop with room left");

endmodule

bind tick_driven_task_scheduler_core tdts_checker u_checker (
  .clk_i, .rst_ni, .empty, .pop, .event_kind_o, .queued_o, .busy_res_o,
  .waiting_total_o
);

// ===== verif/tb_tick_driven_task_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// Testbench for the tick-driven task scheduler core
// Sends arrival and tick requests through the push/full side and checks
// every result, field by field, against a scoreboard that keeps its own
// copy of the scheduler state. Covers all modes, queue overflow, a
// requeue refused by a full queue and a zero quantum, under random
// stalls on both sides.
// ----------------------------------------------------------------------------
module tb_tick_driven_task_scheduler_core;
  import tdts_pkg::*;

  typedef struct {
    logic [7:0]  id;
    logic [7:0]  burst;
    logic [7:0]  prio;
    logic [15:0] arr;
    bit          requeued;
  } task_rec_t;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  task_no;
    logic [15:0] s0;
    logic [15:0] s1;
    logic [31:0] wt;
    logic        busy;
    logic [4:0]  nq;
  } sched_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [7:0]  cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic        cmd_i = 1'b0;
  logic [7:0]  task_id_i = '0;
  logic [7:0]  burst_ticks_i = '0;
  logic [7:0]  prio_level_i = '0;
  logic        more_pending_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  event_kind_o;
  logic [7:0]  event_task_o;
  logic [15:0] span_start_o;
  logic [15:0] span_end_o;
  logic [31:0] waiting_total_o;
  logic        busy_res_o;
  logic [4:0]  queued_o;

  tick_driven_task_scheduler_core uut (.*);

  // Scoreboard copy of the scheduler.
  logic [1:0]  sb_mode = ModeFcfs;
  logic [7:0]  sb_quantum = 8'd2;
  logic [15:0] sb_now = '0;
  task_rec_t   sb_ready[QueueDepth];
  int unsigned sb_count = 0;
  task_rec_t   sb_cur;
  logic [15:0] sb_disp = '0;
  bit          sb_running = 0;
  bit          sb_idle = 0;
  logic [15:0] sb_idle_begin = '0;
  logic [31:0] sb_wait = '0;

  sched_res_t  expected_q[$];
  int          errors = 0;
  int          sent = 0;
  int          checked = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_cycles = 0;
  int unsigned drops_seen = 0;
  int unsigned preempts_seen = 0;

  localparam int StallLimit = 20000;

  // Clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // True if a must be served strictly ahead of b.
  function automatic bit ahead_of(task_rec_t a, task_rec_t b);
    if (sb_mode == ModeSjf && a.burst != b.burst) return a.burst < b.burst;
    if (sb_mode == ModePrio && a.prio != b.prio) return a.prio < b.prio;
    if (a.arr != b.arr) return a.arr < b.arr;
    if (a.requeued != b.requeued) return a.requeued;
    return a.id < b.id;
  endfunction

  // Sorted insertion; first come first served always appends.
  function automatic void ready_insert(task_rec_t e);
    int unsigned pos;
    pos = sb_count;
    if (sb_mode != ModeFcfs) begin
      for (int unsigned i = 0; i < sb_count; i++) begin
        if (ahead_of(e, sb_ready[i])) begin
          pos = i;
          break;
        end
      end
    end
    for (int i = int'(sb_count); i > int'(pos); i--) sb_ready[i] = sb_ready[i-1];
    sb_ready[pos] = e;
    sb_count++;
  endfunction

  // Works out the result of one accepted request and updates the state.
  function automatic void schedule_step(logic c, logic [7:0] id, logic [7:0] b,
                                        logic [7:0] p, logic m);
    sched_res_t r;
    task_rec_t  e;
    logic [15:0] el;
    logic [7:0]  q;
    r = '{EvNone, 8'd0, 16'd0, 16'd0, 32'd0, 1'b0, 5'd0};
    if (c == CmdArrive) begin
      if (sb_count >= QueueDepth) begin
        r.kind = EvDrop;
        r.task_no = id;
      end else begin
        e = '{id, b, p, sb_now, 1'b0};
        ready_insert(e);
      end
    end else begin
      if (sb_running) begin
        el = sb_now - sb_disp;
        q = (sb_quantum == 8'd0) ? 8'd1 : sb_quantum;
        if (el >= {8'd0, sb_cur.burst}) begin
          r.kind = EvFinish;
          r.task_no = sb_cur.id;
          r.s0 = sb_now - {8'd0, sb_cur.burst};
          r.s1 = sb_now;
          sb_wait += {16'd0, 16'(sb_now - {8'd0, sb_cur.burst} - sb_cur.arr)};
          sb_running = 0;
        end else if (sb_mode == ModeRr && sb_count < QueueDepth && el >= {8'd0, q}) begin
          r.kind = EvPreempt;
          r.task_no = sb_cur.id;
          r.s0 = sb_now - {8'd0, q};
          r.s1 = sb_now;
          sb_wait += {16'd0, 16'(sb_now - {8'd0, q} - sb_cur.arr)};
          sb_running = 0;
          e = sb_cur;
          e.arr = sb_now;
          e.burst = sb_cur.burst - q;
          e.requeued = 1;
          ready_insert(e);
        end
      end
      if (!sb_running && sb_count > 0) begin
        if (sb_idle) begin
          r.kind = EvIdle;
          r.task_no = 8'd0;
          r.s0 = sb_idle_begin;
          r.s1 = sb_now;
          sb_idle = 0;
        end
        sb_cur = sb_ready[0];
        sb_count--;
        for (int unsigned i = 0; i < sb_count; i++) sb_ready[i] = sb_ready[i+1];
        sb_running = 1;
        sb_disp = sb_now;
      end
      if (!sb_running && sb_count == 0 && m && !sb_idle) begin
        sb_idle = 1;
        sb_idle_begin = sb_now;
      end
      sb_now = sb_now + 16'd1;
    end
    r.wt = sb_wait;
    r.busy = sb_running;
    r.nq = 5'(sb_count);
    expected_q.push_back(r);
  endfunction

  // Sends one request; push stays high afterwards unless the next call idles.
  task automatic send_req(logic c, logic [7:0] id, logic [7:0] b, logic [7:0] p,
                          logic m);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    cmd_i <= c;
    task_id_i <= id;
    burst_ticks_i <= b;
    prio_level_i <= p;
    more_pending_i <= m;
    do @(posedge clk_i); while (full);
    schedule_step(c, id, b, p, m);
    sent++;
  endtask

  task automatic arrive(logic [7:0] id, logic [7:0] b, logic [7:0] p);
    send_req(CmdArrive, id, b, p, 1'($urandom_range(1)));
  endtask

  task automatic tick(logic m);
    send_req(CmdTick, 8'($urandom), 8'($urandom), 8'($urandom), m);
  endtask

  // Holds the sender until every expected result has arrived.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Register write, only while the block is idle.
  task automatic write_reg(logic idx, logic [7:0] data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegMode) sb_mode = data[1:0];
    else sb_quantum = data;
  endtask

  function automatic void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp_v,
               act_v);
      errors++;
    end
  endfunction

  // Result side: random pops, each accepted result checked in order.
  always @(posedge clk_i) begin
    sched_res_t r;
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no request outstanding (kind %0d)", $time,
                   event_kind_o);
          errors++;
        end else begin
          r = expected_q.pop_front();
          cmp("event_kind", 32'(r.kind), 32'(event_kind_o));
          cmp("event_task", 32'(r.task_no), 32'(event_task_o));
          cmp("span_start", 32'(r.s0), 32'(span_start_o));
          cmp("span_end", 32'(r.s1), 32'(span_end_o));
          cmp("waiting_total", r.wt, waiting_total_o);
          cmp("busy_res", 32'(r.busy), 32'(busy_res_o));
          cmp("queued", 32'(r.nq), 32'(queued_o));
          if (r.kind == EvDrop) drops_seen++;
          if (r.kind == EvPreempt) preempts_seen++;
          checked++;
        end
      end
    end
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles with no handshake at all.
  always @(posedge clk_i) begin
    if (stall_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("** tick_driven_task_scheduler_core: FAILED **");
      $finish;
    end
  end

  // Field extremes, queue overflow and a preempt refused by a full queue.
  task automatic test_queue_full();
    write_reg(RegMode, ModeRr);
    write_reg(RegQuantum, 8'd1);
    tick(1'b1);
    arrive(8'd0, 8'd0, 8'd0);
    arrive(8'd255, 8'd255, 8'd255);
    for (int i = 2; i < 16; i++) arrive(8'(i), 8'd3, 8'($urandom));
    arrive(8'd170, 8'd85, 8'd85);
    tick(1'b0);
    arrive(8'd85, 8'd170, 8'd170);
    tick(1'b0);
    arrive(8'd86, 8'd4, 8'd4);
    tick(1'b1);
    drain();
  endtask

  // Zero quantum behaves as one; zero burst finishes at once.
  task automatic test_zero_quantum();
    write_reg(RegQuantum, 8'd0);
    for (int i = 0; i < 3; i++) tick(1'b0);
    write_reg(RegMode, ModeFcfs);
    arrive(8'd7, 8'd0, 8'd1);
    for (int i = 0; i < 3; i++) tick(1'b1);
    drain();
  endtask

  // Random traffic in one mode and quantum.
  task automatic test_random(logic [1:0] mode, logic [7:0] quantum, int n);
    int arrive_pct;
    write_reg(RegMode, mode);
    write_reg(RegQuantum, quantum);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) arrive_pct = $urandom_range(25, 70);
      if ($urandom_range(99) < arrive_pct) begin
        arrive(8'($urandom),
               ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)),
               ($urandom_range(1)) ? 8'($urandom) : 8'($urandom_range(0, 3)));
      end else begin
        tick(($urandom_range(3) != 0));
      end
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 16;
    recv_idle_pct = 62;
    test_queue_full();
    test_zero_quantum();
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 62;
        recv_idle_pct = 16;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      test_random(ModeFcfs, 8'd2, 140);
      test_random(ModeSjf, 8'($urandom_range(1, 255)), 140);
      test_random(ModePrio, 8'($urandom_range(1, 255)), 140);
      test_random(ModeRr, (ph == 0) ? 8'd1 : (ph == 1) ? 8'd255 : 8'd4, 140);
    end

    $display("Sent %0d requests, checked %0d results, %0d preempts, %0d drops,",
             sent, checked, preempts_seen, drops_seen);
    $display("over all four modes, quanta 0 to 255, overflow and a refused requeue.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** tick_driven_task_scheduler_core: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_q.size());
      $display("** tick_driven_task_scheduler_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tdts_pkg.sv
rtl/tdts_front.sv
rtl/tdts_back.sv
rtl/tick_driven_task_scheduler_core.sv
rtl/tdts_checker.sv
verif/tb_tick_driven_task_scheduler_core.sv
